// ----- src/rpi_pkg.sv -----
// shared constants and pipeline types for the ray / plane intersection block
`timescale 1ns / 1ps

package rpi_pkg;

    // coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // derived widths
    localparam int CW     = COORD_WIDTH;
    localparam int PROD_W = 2 * CW;            // one coordinate product
    localparam int SUM_W  = 2 * CW + 3;        // dot product plus offset term
    localparam int MAG_W  = 2 * CW;            // magnitude of numerator and denominator
    localparam int DIV_W  = 3 * CW;            // numerator times direction magnitude
    localparam int Q_W    = 2 * CW - 2 - FRAC_BITS; // quotient bits needed on a hit
    localparam int P_W    = Q_W + 2;           // hit point before saturation

    // one quotient lane of the divider
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [Q_W-1:0]   sh;
    } div_lane_t;

    // side data traveling with the divider
    typedef struct packed {
        logic                   hit;
        logic [MAG_W-1:0]       den;
        logic [2:0]             neg;
        logic [2:0][CW-1:0]     org;
    } div_side_t;

endpackage

// ----- src/ray_plane_intersection.sv -----
// ray segment / plane intersection, fully pipelined
//
//  channel   handshake          payload
//  request   start / busy       origin_*, dir_*, seg_length, normal_*, plane_offset
//  result    done (one cycle)   hit, hit_x, hit_y, hit_z
//
// one request per cycle; each result passes stages 1 to 4, the divider and the final stage
// in turn (Q16.16 coordinates); the restoring divider gives one quotient bit a stage
// busy is always low: the pipeline never stalls and the receiver cannot hold off
// reset clears the valid bits only; data registers carry no reset
`timescale 1ns / 1ps

module ray_plane_intersection (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [rpi_pkg::COORD_WIDTH-1:0] origin_x,
    input  logic signed [rpi_pkg::COORD_WIDTH-1:0] origin_y,
    input  logic signed [rpi_pkg::COORD_WIDTH-1:0] origin_z,
    input  logic signed [rpi_pkg::COORD_WIDTH-1:0] dir_x,
    input  logic signed [rpi_pkg::COORD_WIDTH-1:0] dir_y,
    input  logic signed [rpi_pkg::COORD_WIDTH-1:0] dir_z,
    input  logic        [rpi_pkg::COORD_WIDTH-2:0] seg_length,
    input  logic signed [rpi_pkg::COORD_WIDTH-1:0] normal_x,
    input  logic signed [rpi_pkg::COORD_WIDTH-1:0] normal_y,
    input  logic signed [rpi_pkg::COORD_WIDTH-1:0] normal_z,
    input  logic signed [rpi_pkg::COORD_WIDTH-1:0] plane_offset,
    output logic                                   done,
    output logic                                   hit,
    output logic signed [rpi_pkg::COORD_WIDTH-1:0] hit_x,
    output logic signed [rpi_pkg::COORD_WIDTH-1:0] hit_y,
    output logic signed [rpi_pkg::COORD_WIDTH-1:0] hit_z
);

    localparam int CW      = rpi_pkg::CW;
    localparam int F       = rpi_pkg::FRAC_BITS;
    localparam int PROD_W  = rpi_pkg::PROD_W;
    localparam int SUM_W   = rpi_pkg::SUM_W;
    localparam int MAG_W   = rpi_pkg::MAG_W;
    localparam int DIV_W   = rpi_pkg::DIV_W;
    localparam int Q_W     = rpi_pkg::Q_W;
    localparam int P_W     = rpi_pkg::P_W;
    localparam int LATENCY = Q_W + 6;

    assign busy = 1'b0;

    // input vectors
    logic signed [CW-1:0] o_in [3];
    logic signed [CW-1:0] d_in [3];
    logic signed [CW-1:0] n_in [3];
    assign o_in[0] = origin_x;
    assign o_in[1] = origin_y;
    assign o_in[2] = origin_z;
    assign d_in[0] = dir_x;
    assign d_in[1] = dir_y;
    assign d_in[2] = dir_z;
    assign n_in[0] = normal_x;
    assign n_in[1] = normal_y;
    assign n_in[2] = normal_z;

    // valid bits of the pipeline stages and the done flag
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [Q_W:0] dv_valid_reg;
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            dv_valid_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            dv_valid_reg <= {dv_valid_reg[Q_W-1:0], s4_valid_reg};
            done_reg     <= dv_valid_reg[Q_W];
        end
    end

    // stage 1: coordinate products
    logic signed [PROD_W-1:0] s1_dn_reg [3];
    logic signed [PROD_W-1:0] s1_no_reg [3];
    logic signed [CW-1:0]     s1_o_reg [3];
    logic signed [CW-1:0]     s1_d_reg [3];
    logic signed [CW-1:0]     s1_off_reg;
    logic        [CW-2:0]     s1_len_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_dn_reg[i] <= PROD_W'(d_in[i] * n_in[i]);
            s1_no_reg[i] <= PROD_W'(n_in[i] * o_in[i]);
            s1_o_reg[i]  <= o_in[i];
            s1_d_reg[i]  <= d_in[i];
        end
        s1_off_reg <= plane_offset;
        s1_len_reg <= seg_length;
    end

    // stage 2: denominator and numerator sums
    logic signed [SUM_W-1:0] den_next, num_next, dot_no;
    logic signed [SUM_W-1:0] s2_den_reg, s2_num_reg;
    logic signed [CW-1:0]    s2_o_reg [3];
    logic signed [CW-1:0]    s2_d_reg [3];
    logic        [CW-2:0]    s2_len_reg;

    always_comb
    begin
        den_next = SUM_W'(s1_dn_reg[0]) + SUM_W'(s1_dn_reg[1]) + SUM_W'(s1_dn_reg[2]);
        dot_no   = SUM_W'(s1_no_reg[0]) + SUM_W'(s1_no_reg[1]) + SUM_W'(s1_no_reg[2])
                 + (SUM_W'(s1_off_reg) <<< F);
        num_next = -dot_no;
    end

    always_ff @(posedge clk)
    begin
        s2_den_reg <= den_next;
        s2_num_reg <= num_next;
        s2_o_reg   <= s1_o_reg;
        s2_d_reg   <= s1_d_reg;
        s2_len_reg <= s1_len_reg;
    end

    // stage 3: sign normalization, magnitudes
    logic signed [SUM_W-1:0] num_flip, den_abs;
    logic                    den_neg;
    logic [MAG_W-1:0]        s3_den_reg, s3_num_reg;
    logic                    s3_ok_reg;
    logic [CW-1:0]           s3_dmag_reg [3];
    logic [2:0]              s3_neg_reg;
    logic signed [CW-1:0]    s3_o_reg [3];
    logic [CW-2:0]           s3_len_reg;

    always_comb
    begin
        den_neg  = s2_den_reg[SUM_W-1];
        num_flip = den_neg ? -s2_num_reg : s2_num_reg;
        den_abs  = den_neg ? -s2_den_reg : s2_den_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_den_reg <= den_abs[MAG_W-1:0];
        s3_num_reg <= num_flip[MAG_W-1:0];
        s3_ok_reg  <= (s2_den_reg != '0) && !num_flip[SUM_W-1] && (num_flip != '0);
        for (int i = 0; i < 3; i++)
        begin
            s3_neg_reg[i]  <= s2_d_reg[i][CW-1];
            s3_dmag_reg[i] <= s2_d_reg[i][CW-1] ? CW'(-s2_d_reg[i]) : CW'(s2_d_reg[i]);
        end
        s3_o_reg   <= s2_o_reg;
        s3_len_reg <= s2_len_reg;
    end

    // stage 4: partial products, all CW by CW
    logic [PROD_W-1:0] s4_pn_lo_reg [3];
    logic [PROD_W-1:0] s4_pn_hi_reg [3];
    logic [PROD_W-1:0] s4_pl_lo_reg, s4_pl_hi_reg;
    logic [MAG_W-1:0]  s4_den_reg, s4_num_reg;
    logic              s4_ok_reg;
    logic [2:0]        s4_neg_reg;
    logic signed [CW-1:0] s4_o_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_pn_lo_reg[i] <= PROD_W'(s3_num_reg[CW-1:0] * s3_dmag_reg[i]);
            s4_pn_hi_reg[i] <= PROD_W'(s3_num_reg[MAG_W-1:CW] * s3_dmag_reg[i]);
        end
        s4_pl_lo_reg <= PROD_W'({1'b0, s3_len_reg} * s3_den_reg[CW-1:0]);
        s4_pl_hi_reg <= PROD_W'({1'b0, s3_len_reg} * s3_den_reg[MAG_W-1:CW]);
        s4_den_reg   <= s3_den_reg;
        s4_num_reg   <= s3_num_reg;
        s4_ok_reg    <= s3_ok_reg;
        s4_neg_reg   <= s3_neg_reg;
        s4_o_reg     <= s3_o_reg;
    end

    // stage 5: range test and divider load
    logic [DIV_W-1:0] dividend [3];
    logic [DIV_W-1:0] lim_rhs, lim_lhs;
    rpi_pkg::div_lane_t [2:0] dv_reg   [Q_W+1];
    rpi_pkg::div_side_t       side_reg [Q_W+1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dividend[i] = ({DIV_W'(s4_pn_hi_reg[i])} << CW) + DIV_W'(s4_pn_lo_reg[i]);
        end
        lim_rhs = ({DIV_W'(s4_pl_hi_reg)} << CW) + DIV_W'(s4_pl_lo_reg);
        lim_lhs = DIV_W'({s4_num_reg, {F{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_reg[0][i].rem     <= MAG_W'(dividend[i][DIV_W-1:Q_W]);
            dv_reg[0][i].sh      <= dividend[i][Q_W-1:0];
            side_reg[0].org[i]   <= s4_o_reg[i];
        end
        side_reg[0].hit <= s4_ok_reg && (lim_lhs < lim_rhs);
        side_reg[0].den <= s4_den_reg;
        side_reg[0].neg <= s4_neg_reg;
    end

    // divider: one quotient bit per stage for each lane
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        logic [MAG_W:0] trial [3];
        logic [2:0]     ge;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {dv_reg[k][i].rem, dv_reg[k][i].sh[Q_W-1]};
                ge[i]    = trial[i] >= {1'b0, side_reg[k].den};
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[k+1][i].rem <= ge[i] ? MAG_W'(trial[i] - {1'b0, side_reg[k].den})
                                            : MAG_W'(trial[i]);
                dv_reg[k+1][i].sh  <= {dv_reg[k][i].sh[Q_W-2:0], ge[i]};
            end
            side_reg[k+1] <= side_reg[k];
        end
    end

    // final stage: sign, add origin, saturate
    logic signed [P_W-1:0] pt   [3];
    logic signed [CW-1:0]  pt_sat [3];
    logic                  out_hit_reg;
    logic signed [CW-1:0]  out_pt_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt[i] = P_W'($signed(side_reg[Q_W].org[i]))
                  + (side_reg[Q_W].neg[i] ? -$signed({2'b00, dv_reg[Q_W][i].sh})
                                          :  $signed({2'b00, dv_reg[Q_W][i].sh}));
            if (pt[i][P_W-1:CW-1] != {(P_W-CW+1){pt[i][P_W-1]}})
            begin
                pt_sat[i] = pt[i][P_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end
            else
            begin
                pt_sat[i] = pt[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg <= side_reg[Q_W].hit;
        for (int i = 0; i < 3; i++)
        begin
            out_pt_reg[i] <= side_reg[Q_W].hit ? pt_sat[i] : '0;
        end
    end

    assign done  = done_reg;
    assign hit   = out_hit_reg;
    assign hit_x = out_pt_reg[0];
    assign hit_y = out_pt_reg[1];
    assign hit_z = out_pt_reg[2];

    // checks
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> hit_x == '0 && hit_y == '0 && hit_z == '0)
        else $error("miss result with nonzero point");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(LATENCY) done)
        else $error("request did not yield a result on time");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[Q_W] && side_reg[Q_W].hit |->
            dv_reg[Q_W][0].rem < side_reg[Q_W].den &&
            dv_reg[Q_W][1].rem < side_reg[Q_W].den &&
            dv_reg[Q_W][2].rem < side_reg[Q_W].den)
        else $error("divider remainder out of range");

endmodule
